>>> rtl/coti_pkg.sv
package coti_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [55:0] entry_time;
    logic signed [31:0] entry_sample;
    logic signed [31:0] entry_line;
    logic signed [55:0] query_time;
  } req_t;

  typedef struct packed {
    logic signed [31:0] sample_angle;
    logic signed [31:0] line_angle;
    logic [1:0]         status;
  } rsp_t;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LOW   = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  // datapath commands
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_SRCH   = 4'd2;  // capture query time, open search range
  localparam logic [3:0] OP_SCMP   = 4'd3;  // compare read data, narrow
  localparam logic [3:0] OP_RDROW  = 4'd4;  // issue read of row row_sel
  localparam logic [3:0] OP_CAPROW = 4'd5;  // capture row row_sel
  localparam logic [3:0] OP_DIVINI = 4'd6;
  localparam logic [3:0] OP_DIVSTP = 4'd7;
  localparam logic [3:0] OP_COEF   = 4'd8;
  localparam logic [3:0] OP_MUL    = 4'd9;
  localparam logic [3:0] OP_ACC    = 4'd10;
  localparam logic [3:0] OP_FIN    = 4'd11;
  localparam logic [3:0] OP_SETPOS = 4'd12;
  localparam logic [3:0] OP_CLEAR  = 4'd13;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic few_rows;
    logic pos_low;
    logic zero_den;
  } stat_t;

endpackage

>>> rtl/coti_datapath.sv
module coti_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  coti_pkg::req_t  req,
  input  coti_pkg::cmd_t  cmd,
  output coti_pkg::stat_t stat,
  output coti_pkg::rsp_t  rsp
);
  import coti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [55:0] tmem [TABLE_DEPTH];
  logic signed [31:0] smem [TABLE_DEPTH];
  logic signed [31:0] lmem [TABLE_DEPTH];

  logic [CW-1:0] row_count, lo, hi, pos;
  logic [AW-1:0] raddr;
  logic signed [55:0] rt;
  logic signed [31:0] rs, rl;
  logic signed [55:0] t0, t1;
  logic signed [31:0] sr [4];
  logic signed [31:0] lr [4];
  logic [CW-1:0] mid;

  assign mid = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && row_count < CW'(TABLE_DEPTH)) begin
      tmem[row_count[AW-1:0]] <= req.entry_time;
      smem[row_count[AW-1:0]] <= req.entry_sample;
      lmem[row_count[AW-1:0]] <= req.entry_line;
    end
    rt <= tmem[raddr];
    rs <= smem[raddr];
    rl <= lmem[raddr];
  end

  // address of row (pos-2+sel), rows idx-1..idx+2
  logic [CW-1:0] row_sel;
  assign row_sel = pos - CW'(2) + CW'(cmd.sel);

  always_comb begin
    if (cmd.op == OP_RDROW) raddr = row_sel[AW-1:0];
    else                    raddr = mid[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      row_count <= '0;
    end else if (cmd.op == OP_LOAD && row_count < CW'(TABLE_DEPTH)) begin
      row_count <= row_count + CW'(1);
    end
  end

  logic signed [55:0] qt;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SRCH) begin
      qt <= req.query_time;
      lo <= '0;
      hi <= row_count;
    end else if (cmd.op == OP_SCMP) begin
      if (rt <= qt) lo <= mid + CW'(1);
      else          hi <= mid;
    end
    if (cmd.op == OP_SETPOS) begin
      if (lo > row_count - CW'(2)) pos <= row_count - CW'(2);
      else                         pos <= lo;
    end
    if (cmd.op == OP_CAPROW) begin
      sr[cmd.sel] <= rs;
      lr[cmd.sel] <= rl;
      if (cmd.sel == 2'd1) t0 <= rt;
      if (cmd.sel == 2'd2) t1 <= rt;
    end
  end

  assign stat.search_done = (lo == hi);
  assign stat.few_rows    = row_count < CW'(2);
  assign stat.pos_low     = pos < CW'(2);
  assign stat.zero_den    = (t0 == t1);

  // serial divider on magnitudes: an * 2^16 / ad, one quotient bit per step
  logic [56:0] an, ad, rem;
  logic        neg;
  logic signed [56:0] num, den;
  assign num = 57'(qt) - 57'(t0);
  assign den = 57'(t1) - 57'(t0);
  logic [57:0] rsh, rsub;
  assign rsh  = {rem, an[56]};
  assign rsub = rsh - {1'b0, ad};

  logic signed [23:0] mult;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIVINI) begin
      neg <= num[56] ^ den[56];
      an  <= num[56] ? -num : num;
      ad  <= den[56] ? -den : den;
      rem <= '0;
    end else if (cmd.op == OP_DIVSTP) begin
      // restoring step; zeros shift in after the numerator bits for the fraction
      an <= {an[55:0], 1'b0};
      if (!rsub[57]) rem <= rsub[56:0];
      else           rem <= rsh[56:0];
    end
  end

  // 57 + 16 quotient bits; any bit above 22 means |mult| >= 128
  logic [72:0] qfull;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIVINI) qfull <= '0;
    else if (cmd.op == OP_DIVSTP) qfull <= {qfull[71:0], !rsub[57]};
  end

  always_comb begin
    if (qfull[72:23] != '0)
      mult = neg ? 24'sh800000 : 24'sh7fffff;
    else if (neg)
      mult = -$signed({1'b0, qfull[22:0]});
    else
      mult = $signed({1'b0, qfull[22:0]});
  end

  // Horner: two lanes share the step count
  localparam logic signed [63:0] LIM = 64'sd549755813888;
  logic signed [39:0] accs, accl;
  logic signed [63:0] ps, pl;
  logic signed [33:0] c3s, c1s, c3l, c1l;
  logic signed [34:0] c2s, c2l;
  logic signed [34:0] addc_s, addc_l;

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    if (v < -LIM)       sat40 = 40'sh8000000000;
    else if (v > LIM - 1) sat40 = 40'sh7fffffffff;
    else                sat40 = v[39:0];
  endfunction

  function automatic logic signed [31:0] negsat(input logic signed [39:0] a);
    logic signed [40:0] n;
    n = -41'(a);
    if (n > 41'sd2147483647)       negsat = 32'sh7fffffff;
    else if (n < -41'sd2147483648) negsat = 32'sh80000000;
    else                           negsat = n[31:0];
  endfunction

  always_comb begin
    c2s = 35'(sr[0]) - 35'(sr[1]) - 35'(c3s);
    c2l = 35'(lr[0]) - 35'(lr[1]) - 35'(c3l);
    unique case (cmd.sel)
      2'd0:    begin addc_s = c2s; addc_l = c2l; end
      2'd1:    begin addc_s = 35'(c1s); addc_l = 35'(c1l); end
      default: begin addc_s = 35'(sr[1]); addc_l = 35'(lr[1]); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COEF) begin
      c3s <= 34'(sr[3]) - 34'(sr[2]) - 34'(sr[0]) + 34'(sr[1]);
      c1s <= 34'(sr[2]) - 34'(sr[0]);
      c3l <= 34'(lr[3]) - 34'(lr[2]) - 34'(lr[0]) + 34'(lr[1]);
      c1l <= 34'(lr[2]) - 34'(lr[0]);
      accs <= 40'(34'(sr[3]) - 34'(sr[2]) - 34'(sr[0]) + 34'(sr[1]));
      accl <= 40'(34'(lr[3]) - 34'(lr[2]) - 34'(lr[0]) + 34'(lr[1]));
    end else if (cmd.op == OP_ACC) begin
      accs <= sat40((ps >>> 16) + 64'(addc_s));
      accl <= sat40((pl >>> 16) + 64'(addc_l));
    end
    if (cmd.op == OP_MUL) begin
      ps <= 64'(accs) * 64'(mult);
      pl <= 64'(accl) * 64'(mult);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      rsp.status <= cmd.sel;
      if (cmd.sel == ST_OK) begin
        rsp.sample_angle <= negsat(accs);
        rsp.line_angle   <= negsat(accl);
      end else begin
        rsp.sample_angle <= '0;
        rsp.line_angle   <= '0;
      end
    end
  end

endmodule

>>> rtl/coti_ctrl.sv
module coti_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      req_type,
  output logic            out_valid,
  input  logic            out_ready,
  input  coti_pkg::stat_t stat,
  output coti_pkg::cmd_t  cmd
);
  import coti_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_SCMP = 4'd2, S_POS = 4'd3,
                         S_RD = 4'd4, S_CAP = 4'd5, S_CHK = 4'd6, S_DINI = 4'd7,
                         S_DIV = 4'd8, S_COEF = 4'd9, S_MUL = 4'd10, S_ACC = 4'd11,
                         S_FIN = 4'd12, S_OUT = 4'd13;

  logic [3:0] state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [1:0] fsel, fsel_next;
  logic       take;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      fsel  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      fsel  <= fsel_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    fsel_next  = fsel;
    cmd.op     = OP_NONE;
    cmd.sel    = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (req_type == REQ_LOAD) cmd.op = OP_LOAD;
          else if (req_type == REQ_CLEAR) cmd.op = OP_CLEAR;
          else if (req_type == REQ_QUERY) begin
            cmd.op = OP_SRCH;
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // the table read at mid runs every cycle; compare it next
        if (stat.search_done) state_next = S_POS;
        else state_next = S_SCMP;
      end
      S_SCMP: begin
        cmd.op = OP_SCMP;
        state_next = S_SRCH;
      end
      S_POS: begin
        cmd.op = OP_SETPOS;
        cnt_next = '0;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.few_rows || stat.pos_low) begin
          fsel_next = ST_LOW;
          state_next = S_FIN;
        end else state_next = S_RD;
      end
      S_RD: begin
        cmd.op = OP_RDROW;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.op = OP_CAPROW;
        cnt_next = cnt + 7'd1;
        if (cnt[1:0] == 2'd3) begin
          state_next = S_DINI;
        end else state_next = S_RD;
      end
      S_DINI: begin
        if (stat.zero_den) begin
          fsel_next = ST_ZERO;
          state_next = S_FIN;
        end else begin
          cmd.op = OP_DIVINI;
          cnt_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIVSTP;
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd72) state_next = S_COEF;
      end
      S_COEF: begin
        cmd.op = OP_COEF;
        cnt_next = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        cnt_next = cnt + 7'd1;
        if (cnt[1:0] == 2'd2) begin
          fsel_next = ST_OK;
          state_next = S_FIN;
        end else state_next = S_MUL;
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        cmd.sel = fsel;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/cubic_offset_table_interpolator.sv
// Cubic offset table interpolator.
// in channel (in_valid/in_ready/in_data): load a row, query, or clear.
// Loads and clears are taken one per cycle while no query is in flight and
// return nothing; a load into a full table is dropped. A query walks an
// upper-bound search over the table memory (up to 11 halvings for 1024 rows),
// reads four rows, runs a 73-step serial divider for the fraction and a
// three-step Horner evaluation on two lanes. A position-low result skips the
// row reads and the divider, a zero-interval result the divider. One
// transaction is in flight at a time.
// out channel (out_valid/out_ready/out_data): one result per query; it is
// held until taken, and no new input is accepted meanwhile.
// Reset empties the table; stored rows are left as is.
module cubic_offset_table_interpolator #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  coti_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output coti_pkg::rsp_t  out_data
);
  import coti_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  coti_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type(in_data.req_type),
    .out_valid, .out_ready, .stat, .cmd
  );

  coti_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .req(in_data), .cmd, .stat, .rsp(out_data)
  );

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import coti_pkg::*;

  localparam int DEPTH = 1024;
  localparam longint LIM40 = 64'sd1 <<< 39;
  localparam int REQ_W = $bits(req_t);
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  cubic_offset_table_interpolator #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the table
  longint row_time[DEPTH];
  longint row_samp[DEPTH];
  longint row_line[DEPTH];
  int unsigned rows;

  rsp_t angle_queue[$];
  int mismatches = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int loads_sent = 0;
  int items_sent = 0;
  int stall_left = 0;
  bit no_idle = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint floor_q16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint frac_q16(longint num, longint den);
    bit neg;
    logic [63:0] an, ad, ip, r, fr;
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= (ad << 7)) return neg ? -(64'sd1 <<< 23) : ((64'sd1 <<< 23) - 1);
    ip = an / ad;
    r = an % ad;
    fr = 0;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      fr = fr << 1;
      if (r >= ad) begin
        r = r - ad;
        fr[0] = 1'b1;
      end
    end
    return neg ? -longint'((ip << 16) | fr) : longint'((ip << 16) | fr);
  endfunction

  function automatic logic [31:0] horner_angle(longint a, longint b, longint c, longint d,
                                               longint m);
    longint c3, c2, c1, acc;
    c3 = d - c - a + b;
    c2 = a - b - c3;
    c1 = c - a;
    acc = clamp(c3, -LIM40, LIM40 - 1);
    acc = clamp(floor_q16(acc * m) + c2, -LIM40, LIM40 - 1);
    acc = clamp(floor_q16(acc * m) + c1, -LIM40, LIM40 - 1);
    acc = clamp(floor_q16(acc * m) + b, -LIM40, LIM40 - 1);
    return 32'(clamp(-acc, -64'sd2147483648, 64'sd2147483647));
  endfunction

  // returns 1 when the item produces a result
  function automatic bit predict_angles(req_t it, output rsp_t res);
    int unsigned lo, hi, mid, pos, ix;
    longint q, den, m;
    res = '0;
    if (it.req_type == REQ_LOAD) begin
      if (rows < DEPTH) begin
        row_time[rows] = it.entry_time;
        row_samp[rows] = it.entry_sample;
        row_line[rows] = it.entry_line;
        rows++;
      end
      return 0;
    end
    if (it.req_type == REQ_CLEAR) begin
      rows = 0;
      return 0;
    end
    if (it.req_type != REQ_QUERY) return 0;
    q = it.query_time;
    lo = 0;
    hi = rows;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (row_time[mid] <= q) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    if (rows < 2) begin
      res.status = ST_LOW;
      return 1;
    end
    if (pos > rows - 2) pos = rows - 2;
    if (pos < 2) begin
      res.status = ST_LOW;
      return 1;
    end
    ix = pos - 1;
    den = row_time[ix + 1] - row_time[ix];
    if (den == 0) begin
      res.status = ST_ZERO;
      return 1;
    end
    m = frac_q16(q - row_time[ix], den);
    res.sample_angle = horner_angle(row_samp[ix-1], row_samp[ix], row_samp[ix+1],
                                    row_samp[ix+2], m);
    res.line_angle = horner_angle(row_line[ix-1], row_line[ix], row_line[ix+1],
                                  row_line[ix+2], m);
    res.status = ST_OK;
    return 1;
  endfunction

  task automatic send_item(req_t it);
    rsp_t res;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_angles(it, res)) begin
      angle_queue.insert(angle_queue.size(), res);
      queries_sent++;
    end
    if (it.req_type == REQ_LOAD) loads_sent++;
    items_sent++;
  endtask

  function automatic req_t mk_load(longint t, logic [31:0] s, logic [31:0] l);
    req_t it;
    it = '0;
    it.req_type = REQ_LOAD;
    it.entry_time = 56'(t);
    it.entry_sample = s;
    it.entry_line = l;
    it.query_time = 56'({$urandom, $urandom});
    return it;
  endfunction

  function automatic req_t mk_query(longint t);
    req_t it;
    it = '0;
    it.req_type = REQ_QUERY;
    it.query_time = 56'(t);
    it.entry_time = 56'({$urandom, $urandom});
    it.entry_sample = $urandom;
    it.entry_line = $urandom;
    return it;
  endfunction

  function automatic req_t mk_ctl(logic [1:0] k);
    req_t it;
    it = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.req_type = k;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = angle_queue.pop_front();
        if (exp_r.sample_angle !== out_data.sample_angle ||
            exp_r.line_angle !== out_data.line_angle ||
            exp_r.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp s=%0d l=%0d st=%0d got s=%0d l=%0d st=%0d",
                     exp_r.sample_angle, exp_r.line_angle, exp_r.status,
                     out_data.sample_angle, out_data.line_angle, out_data.status);
        end
      end
    end
  end

  // receiver stalls: mostly short, now and then a long hold-off
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (r < 2) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(10, 60);
    end else if (r < 65) out_ready <= 1'b1;
    else out_ready <= 1'b0;
  end

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (angle_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_and_ctl();
    send_item(mk_query(0));
    send_item(mk_load(56'sh10_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk_query(56'sh10_0000));
    send_item(mk_ctl(REQ_UNUSED));
    send_item(mk_ctl(REQ_CLEAR));
    send_item(mk_query(56'sh7F_FFFF_FFFF_FFFF));
  endtask

  task automatic test_extremes();
    send_item(mk_ctl(REQ_CLEAR));
    send_item(mk_load(-(64'sd1 <<< 55), 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(mk_load(-(64'sd1 <<< 20), 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk_load(0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(mk_load(64'sd1 <<< 20, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk_load((64'sd1 <<< 55) - 1, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(mk_query(-(64'sd1 <<< 55)));
    send_item(mk_query(64'sd1 <<< 19));
    send_item(mk_query(-(64'sd1 <<< 19)));
    send_item(mk_query((64'sd1 <<< 55) - 1));
    send_item(mk_query(64'sd1 <<< 30));
    // zero interval
    send_item(mk_ctl(REQ_CLEAR));
    for (int k = 0; k < 6; k++) send_item(mk_load(k < 3 ? 0 : 1000, k, -k));
    send_item(mk_query(500));
    send_item(mk_query(1000));
  endtask

  task automatic test_full_table();
    send_item(mk_ctl(REQ_CLEAR));
    for (int k = 0; k < DEPTH + 3; k++)
      send_item(mk_load(longint'(k) * 4096, $urandom, $urandom));
    for (int k = 0; k < 6; k++)
      send_item(mk_query(longint'($urandom_range(0, DEPTH * 4096 + 9000)) - 2000));
  endtask

  task automatic test_random_tables();
    int n;
    longint t, step;
    while (items_sent < 1850) begin
      send_item(mk_ctl(REQ_CLEAR));
      n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 24);
      t = {$urandom, $urandom};
      t = t >>> 12;
      step = $urandom_range(0, 9) == 0 ? {$urandom, $urandom} >>> 10
                                        : $urandom_range(0, 1 << 20);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(mk_load({$urandom, $urandom}, $urandom, $urandom));
        else
          send_item(mk_load(t, $urandom_range(0, 3) == 0 ? $urandom
                                 : $urandom_range(0, 1 << 22) - (1 << 21),
                            $urandom_range(0, 3) == 0 ? $urandom
                                 : $urandom_range(0, 1 << 22) - (1 << 21)));
        t = t + ($urandom_range(0, 15) == 0 ? 0 : step + $urandom_range(0, 1000));
        if ($urandom_range(0, 29) == 0) send_item(mk_ctl(REQ_UNUSED));
      end
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(mk_query({$urandom, $urandom}));
        else
          send_item(mk_query(t - longint'($urandom_range(0, n + 2)) * step
                             - $urandom_range(0, 5000)));
      end
      // hold off until the block has answered everything
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  task automatic test_no_idle();
    no_idle = 1;
    send_item(mk_ctl(REQ_CLEAR));
    for (int k = 0; k < 10; k++) send_item(mk_load(k * 7777, $urandom, $urandom));
    for (int k = 0; k < 20; k++) send_item(mk_query($urandom_range(0, 80000)));
    drain();
    no_idle = 0;
  endtask

  initial begin
    rows = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_ctl();
    test_extremes();
    drain();
    test_full_table();
    test_no_idle();
    test_random_tables();
    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d row loads and %0d queries, %0d results checked.",
             loads_sent, queries_sent, results_seen);
    $display("Tables included empty, full, unordered and repeated-time cases.");
    if (mismatches == 0 && angle_queue.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end
endmodule
